// ----- hdl/median_filter_3x3_assert.svh -----
// Assertion macros used by the median filter checker.
`ifndef MEDIAN_FILTER_3X3_ASSERT_SVH
`define MEDIAN_FILTER_3X3_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MF3_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define MF3_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/mf3_pkg.sv -----
// Types, register codes and the 9-input median network of the 3x3 median filter.
package mf3_pkg;

	localparam int PIX_W      = 8;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	typedef logic [PIX_W-1:0]      pix_t;
	typedef logic [WIDTH_W-1:0]    width_t;
	typedef logic [HEIGHT_W-1:0]   height_t;
	typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
	typedef logic [CFG_DATA_W-1:0] cfg_data_t;
	typedef logic [8:0][PIX_W-1:0] win9_t;

	localparam cfg_idx_t REG_WIDTH  = cfg_idx_t'(0);
	localparam cfg_idx_t REG_HEIGHT = cfg_idx_t'(1);

	// returns {min, max}
	function automatic logic [2*PIX_W-1:0] sort2(pix_t a, pix_t b);
		return (a > b) ? {b, a} : {a, b};
	endfunction

	// 19 compare-exchange network, result lands in element 4
	function automatic pix_t median9(win9_t w);
		win9_t v;
		v = w;
		{v[1], v[2]} = sort2(v[1], v[2]);
		{v[4], v[5]} = sort2(v[4], v[5]);
		{v[7], v[8]} = sort2(v[7], v[8]);
		{v[0], v[1]} = sort2(v[0], v[1]);
		{v[3], v[4]} = sort2(v[3], v[4]);
		{v[6], v[7]} = sort2(v[6], v[7]);
		{v[1], v[2]} = sort2(v[1], v[2]);
		{v[4], v[5]} = sort2(v[4], v[5]);
		{v[7], v[8]} = sort2(v[7], v[8]);
		{v[0], v[3]} = sort2(v[0], v[3]);
		{v[5], v[8]} = sort2(v[5], v[8]);
		{v[4], v[7]} = sort2(v[4], v[7]);
		{v[3], v[6]} = sort2(v[3], v[6]);
		{v[1], v[4]} = sort2(v[1], v[4]);
		{v[2], v[5]} = sort2(v[2], v[5]);
		{v[4], v[7]} = sort2(v[4], v[7]);
		{v[4], v[2]} = sort2(v[4], v[2]);
		{v[6], v[4]} = sort2(v[6], v[4]);
		{v[4], v[2]} = sort2(v[4], v[2]);
		return v[4];
	endfunction

endpackage

// ----- hdl/median_filter_3x3.sv -----
// 3x3 median filter over a raster pixel stream, top level.
// A pixel passes the stage-1 registers and then the median output register; a stalled output can hold stage 1.
// Throughput: one pixel per cycle while in_stall is low; the line memories take one read and one write per cycle.
// A pixel is stalled only while a finished median waits at a stalled output.
// Reset: counters, window and valids clear, width and height return to 1024;
// the line memories are not cleared.
module median_filter_3x3 #(
	parameter int MAX_WIDTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  mf3_pkg::cfg_idx_t   cfg_index,
	input  mf3_pkg::cfg_data_t  cfg_data,
	input  logic                in_valid,
	output logic                in_stall,
	input  mf3_pkg::pix_t       pixel,
	output logic                out_valid,
	input  logic                out_stall,
	output mf3_pkg::pix_t       median,
	output logic                last
);
	import mf3_pkg::*;

	localparam int CW = (MAX_WIDTH > 2) ? $clog2(MAX_WIDTH) : 1;

	width_t          width_q;
	height_t         height_q;
	logic [CW-1:0]   col_q;
	height_t         row_q;
	logic [CW-1:0]   col_last;
	height_t         row_last;
	logic [31:0]     width_ext;

	pix_t            top_mem [MAX_WIDTH];
	pix_t            mid_mem [MAX_WIDTH];

	logic            s1_valid_q;
	pix_t            pix_s1;
	logic [CW-1:0]   col_s1;
	logic            emit_s1;
	logic            last_s1;
	pix_t            top_rd_s1;
	pix_t            mid_rd_s1;

	pix_t            win_q [6];
	logic            out_valid_q;
	pix_t            median_q;
	logic            last_q;

	logic            cfg_wr;
	logic            in_acc;
	logic            s1_adv;
	win9_t           win9;

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid & cfg_ready;

	always_comb begin
		width_ext = 32'(width_q);
		if (width_ext < 32'd3) begin
			col_last = CW'(2);
		end else if (width_ext > 32'(MAX_WIDTH)) begin
			col_last = CW'(MAX_WIDTH - 1);
		end else begin
			col_last = CW'(width_ext - 32'd1);
		end
		row_last = (height_q < height_t'(3)) ? height_t'(2) : height_q - height_t'(1);
	end

	assign s1_adv   = s1_valid_q & (~emit_s1 | ~out_valid_q | ~out_stall);
	assign in_stall = s1_valid_q & ~s1_adv;
	assign in_acc   = in_valid & ~in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= width_t'(1024);
			height_q <= height_t'(1024);
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wr) begin
			unique case (cfg_index)
				REG_WIDTH: begin
					width_q <= cfg_data[WIDTH_W-1:0];
					col_q   <= '0;
					row_q   <= '0;
				end
				REG_HEIGHT: begin
					height_q <= cfg_data[HEIGHT_W-1:0];
					col_q    <= '0;
					row_q    <= '0;
				end
				default: begin
				end
			endcase
		end else if (in_acc) begin
			if (col_q == col_last) begin
				col_q <= '0;
				row_q <= (row_q == row_last) ? '0 : row_q + height_t'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			top_rd_s1 <= top_mem[col_q];
			mid_rd_s1 <= mid_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			top_mem[col_s1] <= mid_rd_s1;
			mid_mem[col_s1] <= pix_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			pix_s1  <= pixel;
			col_s1  <= col_q;
			emit_s1 <= (row_q >= height_t'(2)) && (col_q >= CW'(2));
			last_s1 <= (row_q == row_last) && (col_q == col_last);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_acc) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (cfg_wr && (cfg_index == REG_WIDTH || cfg_index == REG_HEIGHT)) begin
			for (int i = 0; i < 6; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			win_q[0] <= win_q[3];
			win_q[1] <= win_q[4];
			win_q[2] <= win_q[5];
			win_q[3] <= top_rd_s1;
			win_q[4] <= mid_rd_s1;
			win_q[5] <= pix_s1;
		end
	end

	assign win9 = {pix_s1, mid_rd_s1, top_rd_s1,
		win_q[5], win_q[4], win_q[3], win_q[2], win_q[1], win_q[0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_adv && emit_s1) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit_s1) begin
			median_q <= median9(win9);
			last_q   <= last_s1;
		end
	end

	assign out_valid = out_valid_q;
	assign median    = median_q;
	assign last      = last_q;

endmodule

// ----- hdl/mf3_checker.sv -----
// Port-level checker for the 3x3 median filter, bound to the top level.
`include "median_filter_3x3_assert.svh"

module mf3_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       in_valid,
	input logic       in_stall,
	input logic       out_valid,
	input logic       out_stall,
	input logic [7:0] median,
	input logic       last
);

	// input backs up only behind a blocked result
	`MF3_ASSERT_NOW(a_stall_cause, in_stall, out_valid && out_stall, "input stalled without a blocked result")

	`MF3_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(median) && $stable(last), "stalled result beat changed")

	// a result needs an earlier accepted pixel or a result already pending
	`MF3_ASSERT_NOW(a_no_phantom, !$past(out_valid) && !$past(out_valid, 2) && !$past(in_valid && !in_stall, 2), !out_valid, "result beat without a source pixel")

endmodule

bind median_filter_3x3 mf3_checker u_mf3_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.median    (median),
	.last      (last)
);

// ----- bench/tb_median_filter_3x3.sv -----
// Self-checking testbench for median_filter_3x3: scripted and random pixel streams checked beat by beat.
module tb_median_filter_3x3;
	timeunit 1ns;
	timeprecision 1ps;

	import mf3_pkg::*;

	localparam int MAX_W = 1024;
	localparam cfg_idx_t IDX_SPARE_A = cfg_idx_t'(2);
	localparam cfg_idx_t IDX_SPARE_B = cfg_idx_t'(3);

	typedef enum logic [1:0] {ROW_CFG, ROW_PIX, ROW_PIX_CHK} row_kind_t;

	typedef struct packed {
		row_kind_t kind;
		cfg_idx_t  idx;
		cfg_data_t data;
		pix_t      pix;
		pix_t      med;
		logic      lst;
	} script_row_t;

	typedef struct {
		pix_t med;
		logic lst;
	} median_due_t;

	localparam script_row_t SCRIPT [0:30] = '{
		'{ROW_CFG, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_CFG, REG_HEIGHT, 16'd2, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX_CHK, REG_WIDTH, 16'd0, 8'd255, 8'd255, 1'b1},
		// back-to-back image, counters wrap
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX_CHK, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b1},
		// unused indexes leave the image running
		'{ROW_CFG, IDX_SPARE_A, 16'hFFFF, 8'd0, 8'd0, 1'b0},
		'{ROW_CFG, IDX_SPARE_B, 16'h5A5A, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd0, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd255, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd1, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd128, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd254, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd127, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd2, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd253, 8'd0, 1'b0},
		'{ROW_PIX, REG_WIDTH, 16'd0, 8'd64, 8'd0, 1'b0}
	};

	logic      clk = 1'b0;
	logic      arst_n = 1'b0;
	logic      cfg_valid = 1'b0;
	logic      cfg_ready;
	cfg_idx_t  cfg_index = '0;
	cfg_data_t cfg_data = '0;
	logic      in_valid = 1'b0;
	logic      in_stall;
	pix_t      pixel = '0;
	logic      out_valid;
	logic      out_stall;
	pix_t      median;
	logic      last;

	// filter state as seen by the checker
	pix_t        row_two_up [MAX_W];
	pix_t        row_one_up [MAX_W];
	pix_t        win_cols [6] = '{default: '0};
	int unsigned col_pos = 0;
	int unsigned row_pos = 0;
	width_t      width_reg = width_t'(1024);
	height_t     height_reg = height_t'(1024);

	median_due_t medians_due [$];
	median_due_t got_due;
	int unsigned mismatches = 0;
	int unsigned pixels_in = 0;
	int unsigned stall_left = 0;
	logic        hold_off = 1'b0;
	logic        calm = 1'b0;

	median_filter_3x3 #(.MAX_WIDTH(MAX_W)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.median(median),
		.last(last)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	assign out_stall = (stall_left != 0) || hold_off;

	function automatic int unsigned eff_width();
		if (width_reg < 3) return 3;
		if (width_reg > MAX_W) return MAX_W;
		return width_reg;
	endfunction

	function automatic int unsigned eff_height();
		return (height_reg < 3) ? 3 : height_reg;
	endfunction

	function automatic pix_t median_of_nine(input pix_t v [9]);
		int below;
		int upto;
		for (int i = 0; i < 9; i++) begin
			below = 0;
			upto = 0;
			for (int j = 0; j < 9; j++) begin
				if (v[j] < v[i]) below++;
				if (v[j] <= v[i]) upto++;
			end
			if (below <= 4 && upto >= 5) return v[i];
		end
		return v[0];
	endfunction

	function automatic void apply_register(input cfg_idx_t idx, input cfg_data_t data);
		case (idx)
			REG_WIDTH: begin
				width_reg = data[WIDTH_W-1:0];
			end
			REG_HEIGHT: begin
				height_reg = data;
			end
			default: begin
				return;
			end
		endcase
		win_cols = '{default: '0};
		col_pos = 0;
		row_pos = 0;
	endfunction

	function automatic void filter_step(input pix_t p, output bit made, output median_due_t due);
		int unsigned w;
		int unsigned h;
		int unsigned c;
		int unsigned r;
		pix_t top;
		pix_t mid;
		pix_t nine [9];
		w = eff_width();
		h = eff_height();
		c = (col_pos >= w) ? w - 1 : col_pos;
		r = (row_pos >= h) ? h - 1 : row_pos;
		top = row_two_up[c];
		mid = row_one_up[c];
		row_two_up[c] = mid;
		row_one_up[c] = p;
		made = (r >= 2 && c >= 2);
		if (made) begin
			for (int i = 0; i < 6; i++) nine[i] = win_cols[i];
			nine[6] = top;
			nine[7] = mid;
			nine[8] = p;
			due.med = median_of_nine(nine);
			due.lst = (r == h - 1 && c == w - 1);
		end
		win_cols[0] = win_cols[3];
		win_cols[1] = win_cols[4];
		win_cols[2] = win_cols[5];
		win_cols[3] = top;
		win_cols[4] = mid;
		win_cols[5] = p;
		if (c + 1 >= w) begin
			col_pos = 0;
			row_pos = (r + 1 >= h) ? 0 : r + 1;
		end else begin
			col_pos = c + 1;
			row_pos = r;
		end
	endfunction

	function automatic pix_t draw_pixel(input int unsigned mode);
		case (mode)
			1: return pix_t'(126 + $urandom_range(0, 3));
			2: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
			default: return pix_t'($urandom_range(0, 255));
		endcase
	endfunction

	task automatic report_mismatch(input string what);
		mismatches++;
		if (mismatches <= 200) $display("MISMATCH at %0t ns: %s", $time, what);
	endtask

	task automatic push_pixel(input pix_t p, input bit typed, input pix_t t_med, input logic t_last);
		bit made;
		median_due_t due;
		if (!calm && $urandom_range(0, 7) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		filter_step(p, made, due);
		if (made) begin
			if (typed) begin
				due.med = t_med;
				due.lst = t_last;
			end
			medians_due.push_back(due);
		end
		in_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (in_stall);
		pixels_in++;
	endtask

	task automatic write_reg(input cfg_idx_t idx, input cfg_data_t data);
		in_valid <= 1'b0;
		while (medians_due.size() != 0) @(posedge clk);
		repeat (6) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		apply_register(idx, data);
	endtask

	task automatic run_pixels(input int unsigned count, input int unsigned mode);
		for (int unsigned i = 0; i < count; i++) push_pixel(draw_pixel(mode), 1'b0, '0, 1'b0);
	endtask

	task automatic set_size(input width_t w, input height_t hgt);
		cfg_data_t wdata;
		wdata = {5'($urandom_range(0, 31)), w};
		if ($urandom_range(0, 1)) begin
			write_reg(REG_WIDTH, wdata);
			write_reg(REG_HEIGHT, hgt);
		end else begin
			write_reg(REG_HEIGHT, hgt);
			write_reg(REG_WIDTH, wdata);
		end
	endtask

	// output side: check each beat, random stall bursts
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (medians_due.size() == 0) begin
				report_mismatch($sformatf("median %0d last %0d with nothing due", median, last));
			end else begin
				got_due = medians_due.pop_front();
				if (median !== got_due.med)
					report_mismatch($sformatf("median %0d, want %0d", median, got_due.med));
				if (last !== got_due.lst)
					report_mismatch($sformatf("last %0b, want %0b", last, got_due.lst));
			end
		end
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
		end else if (!calm && $urandom_range(0, 9) == 0) begin
			stall_left <= $urandom_range(1, 17);
		end
	end

	// long hold-off during the tall image so the pipeline backs up
	initial begin
		wait (pixels_in >= 150);
		@(posedge clk);
		hold_off <= 1'b1;
		repeat (300) @(posedge clk);
		hold_off <= 1'b0;
	end

	initial begin
		int unsigned n;
		int unsigned mode;
		int unsigned sel;
		int unsigned small_done;
		width_t w;
		height_t hgt;
		small_done = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset sizes, four pixels of the first row only
		run_pixels(4, 0);
		foreach (SCRIPT[i]) begin
			if (SCRIPT[i].kind == ROW_CFG)
				write_reg(SCRIPT[i].idx, SCRIPT[i].data);
			else
				push_pixel(SCRIPT[i].pix, SCRIPT[i].kind == ROW_PIX_CHK, SCRIPT[i].med, SCRIPT[i].lst);
		end

		// tallest height, a stream of 300 random pixels through the hold-off
		set_size(width_t'(12), height_t'(16'hFFFF));
		run_pixels(300, 3);

		while (small_done < 900) begin
			calm <= ($urandom_range(0, 4) == 0);
			mode = $urandom_range(0, 3);
			sel = $urandom_range(0, 9);
			if (sel == 0) begin
				write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B, cfg_data_t'($urandom));
				n = $urandom_range(1, 30);
			end else begin
				w = (sel == 1) ? width_t'($urandom_range(0, 2)) : width_t'($urandom_range(3, 12));
				if (sel == 2) hgt = height_t'($urandom_range(0, 2));
				else if (sel == 3) hgt = 16'hFFFF;
				else hgt = height_t'($urandom_range(3, 8));
				set_size(w, hgt);
				if ($urandom_range(0, 5) == 0)
					write_reg($urandom_range(0, 1) ? IDX_SPARE_A : IDX_SPARE_B,
						cfg_data_t'($urandom));
				if (sel == 3)
					n = eff_width() * $urandom_range(3, 7) + $urandom_range(0, eff_width() - 1);
				else if ($urandom_range(0, 3) == 0)
					n = $urandom_range(1, eff_width() * eff_height() - 1);
				else
					n = eff_width() * eff_height() * $urandom_range(1, 2);
			end
			run_pixels(n, mode);
			small_done += n;
		end

		// closing stretch without idling
		calm <= 1'b1;
		set_size(width_t'($urandom_range(3, 12)), height_t'($urandom_range(3, 8)));
		run_pixels(eff_width() * eff_height(), 0);
		in_valid <= 1'b0;

		while (medians_due.size() != 0) @(posedge clk);
		repeat (10) @(posedge clk);
		if (mismatches == 0) begin
			$display("end of test: clean");
		end else begin
			$display("end of test: mismatches");
		end
		$finish;
	end

	initial begin
		#10_000_000;
		$display("end of test: mismatches");
		$finish;
	end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/mf3_pkg.sv
hdl/median_filter_3x3.sv
hdl/mf3_checker.sv
bench/tb_median_filter_3x3.sv
